/* rtl/core/toc_pkg.sv */
// Shared definitions for the tilt orientation classifier.
// Holds field widths, register indexes, reset values and the arctangent table.
// Used by the top level, the CORDIC and the testbench; depends on nothing.
package toc_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int FIELD_W    = 16;
	localparam int GAIN_W     = 32;
	localparam int GAIN_FRAC  = 24;
	localparam int THR_W      = 7;
	localparam int ANGLE_W    = 8;
	localparam int ORIENT_W   = 3;
	localparam int CFG_IDX_W  = 2;

	localparam int GUARD_BITS = 28;
	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W     = 22;
	localparam int ANGLE_FRAC = 16;
	localparam int Z_W        = 25;
	localparam int MAX_TILT   = 90;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE_THR = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd16777216;
	localparam logic [THR_W-1:0]  THR_RESET  = 7'd35;

	typedef enum logic [ORIENT_W-1:0] {
		ORIENT_UNDEFINED = 3'd0,
		ORIENT_NORMAL    = 3'd1,
		ORIENT_BOTTOM_UP = 3'd2,
		ORIENT_LEFT_UP   = 3'd3,
		ORIENT_RIGHT_UP  = 3'd4
	} orient_t;

	// Arctangent of 2^-idx in degrees, Q16.
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/tilt_orientation_classifier.sv */
// Top level of the tilt orientation classifier: sequencer, shared multiplier,
// configuration registers and output register. Depends on toc_pkg, toc_isqrt
// and toc_cordic.
//
// Channel   Dir  Width  Contents (lowest bits first)
// s_axis    in   48     accel_x, accel_y, accel_z
// m_axis    out  24     orientation, changed, portrait_angle, landscape_angle
// cfg       in   2+32   register index, write data
//
// The time per word is set by the square root unit, one bit per cycle, and the CORDIC,
// one rotation per cycle, each run once for each of the two tilts.
// A finished result waits in the output register, and the next word is taken
// while it waits; the sequencer holds in its last state only while the output
// register is still full. Reset loads the configuration reset values and clears
// the state, the data registers, the stored orientation and the output register.
module tilt_orientation_classifier #(
	parameter int SAMPLE_BITS  = toc_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = toc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32].
	input  logic [3*toc_pkg::FIELD_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// orientation [2:0], changed [3], portrait_angle [11:4],
	// landscape_angle [19:12], zeros [23:20].
	output logic [23:0]                   m_axis_tdata,
	input  logic                          cfg_wr_en,
	input  logic [toc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [toc_pkg::GAIN_W-1:0]    cfg_wdata
);
	import toc_pkg::*;

	localparam int AXES    = 3;
	localparam int SB      = SAMPLE_BITS;
	localparam int SCL_W   = SB + GAIN_W - GAIN_FRAC;
	localparam int SQ_W    = 2 * SCL_W;
	localparam int ROOT_W  = SCL_W + 1;
	localparam int MUL_A_W = SCL_W;
	localparam int MUL_B_W = (SCL_W > GAIN_W) ? SCL_W : GAIN_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int OUT_FW  = ORIENT_W + 1 + 2 * ANGLE_W;
	localparam int OUT_W   = ((OUT_FW + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_ANGLE_WAIT,
		ST_DONE
	} seq_t;

	seq_t                      state_q;
	logic [1:0]                cnt_q;
	logic                      sel_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [THR_W-1:0]          pthr_q;
	logic [THR_W-1:0]          lthr_q;
	orient_t                   last_q;
	logic                      neg_q [AXES];
	logic [SB-1:0]             mag_q [AXES];
	logic [SCL_W-1:0]          scl_q [AXES];
	logic [SQ_W-1:0]           sq_q  [AXES];
	logic signed [ANGLE_W-1:0] pa_q;
	logic signed [ANGLE_W-1:0] la_q;
	logic                      out_valid_q;
	logic [OUT_W-1:0]          out_data_q;

	logic [SB-1:0]             raw    [AXES];
	logic                      in_neg [AXES];
	logic [SB-1:0]             in_mag [AXES];
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [PROD_W-1:0]         prod;
	logic [SQ_W:0]             sum;
	logic                      root_start;
	logic                      root_done;
	logic [ROOT_W-1:0]         root;
	logic                      ang_start;
	logic                      ang_done;
	logic signed [ANGLE_W-1:0] ang;
	logic                      in_take;
	logic                      out_load;
	logic [ANGLE_W-1:0]        pabs;
	logic [ANGLE_W-1:0]        labs;
	logic                      p_hi;
	logic                      l_hi;
	orient_t                   next_orient;

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			raw[k]    = SB'(s_axis_tdata[k*FIELD_W +: FIELD_W]);
			in_neg[k] = raw[k][SB-1];
			in_mag[k] = in_neg[k] ? SB'(-raw[k]) : raw[k];
		end
	end

	// One multiplier serves the three gain products and then the three squares.
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = MUL_A_W'(mag_q[cnt_q]);
			mul_b = MUL_B_W'(gain_q);
		end else begin
			mul_a = MUL_A_W'(scl_q[cnt_q]);
			mul_b = MUL_B_W'(scl_q[cnt_q]);
		end
		prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	assign sum = sel_q ? ((SQ_W+1)'(sq_q[0]) + (SQ_W+1)'(sq_q[2]))
	                   : ((SQ_W+1)'(sq_q[1]) + (SQ_W+1)'(sq_q[2]));

	assign root_start = (state_q == ST_ROOT);
	assign ang_start  = (state_q == ST_ROOT_WAIT) && root_done;

	toc_isqrt #(
		.ROOT_W(ROOT_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand((2*ROOT_W)'(sum)),
		.done    (root_done),
		.root    (root)
	);

	toc_cordic #(
		.MAG_W(SCL_W),
		.DEN_W(ROOT_W),
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ang_start),
		.num_neg(sel_q ? neg_q[1] : neg_q[0]),
		.num_mag(sel_q ? scl_q[1] : scl_q[0]),
		.den    (root),
		.done   (ang_done),
		.angle  (ang)
	);

	always_comb begin
		pabs = pa_q[ANGLE_W-1] ? ANGLE_W'(-pa_q) : ANGLE_W'(pa_q);
		labs = la_q[ANGLE_W-1] ? ANGLE_W'(-la_q) : ANGLE_W'(la_q);
		p_hi = pabs > ANGLE_W'(pthr_q);
		l_hi = labs > ANGLE_W'(lthr_q);
		next_orient = last_q;
		if (p_hi && !l_hi) begin
			next_orient = (!pa_q[ANGLE_W-1] && pa_q != '0) ? ORIENT_LEFT_UP : ORIENT_RIGHT_UP;
		end else if (!p_hi && l_hi) begin
			next_orient = (!la_q[ANGLE_W-1] && la_q != '0) ? ORIENT_BOTTOM_UP : ORIENT_NORMAL;
		end
	end

	assign in_take  = s_axis_tvalid && (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			gain_q      <= GAIN_RESET;
			pthr_q      <= THR_RESET;
			lthr_q      <= THR_RESET;
			last_q      <= ORIENT_UNDEFINED;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			pa_q        <= '0;
			la_q        <= '0;
			for (int k = 0; k < AXES; k++) begin
				neg_q[k] <= 1'b0;
				mag_q[k] <= '0;
				scl_q[k] <= '0;
				sq_q[k]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_AXIS_GAIN:     gain_q <= cfg_wdata;
					REG_PORTRAIT_THR:  pthr_q <= cfg_wdata[THR_W-1:0];
					REG_LANDSCAPE_THR: lthr_q <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						for (int k = 0; k < AXES; k++) begin
							neg_q[k] <= in_neg[k];
							mag_q[k] <= in_mag[k];
						end
						cnt_q   <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					scl_q[cnt_q] <= prod[GAIN_FRAC +: SCL_W];
					if (cnt_q == 2'd2) begin
						cnt_q   <= '0;
						state_q <= ST_SQUARE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQUARE: begin
					sq_q[cnt_q] <= prod[SQ_W-1:0];
					if (cnt_q == 2'd2) begin
						cnt_q   <= '0;
						sel_q   <= 1'b0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					state_q <= ST_ROOT_WAIT;
				end
				ST_ROOT_WAIT: begin
					if (root_done) begin
						state_q <= ST_ANGLE_WAIT;
					end
				end
				ST_ANGLE_WAIT: begin
					if (ang_done) begin
						if (sel_q) begin
							la_q    <= ang;
							state_q <= ST_DONE;
						end else begin
							pa_q    <= ang;
							sel_q   <= 1'b1;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_data_q  <= OUT_W'({la_q, pa_q, (next_orient != last_q), next_orient});
						out_valid_q <= 1'b1;
						last_q      <= next_orient;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/core/toc_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
// Depends on nothing; used by the tilt orientation classifier.
module toc_isqrt #(
	parameter int ROOT_W = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*ROOT_W-1:0] radicand,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+1:0]   rem_sh;
	logic [ROOT_W+1:0]   trial;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[2*ROOT_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/core/toc_cordic.sv */
// Vectoring CORDIC that turns a numerator and a non-negative denominator into
// a tilt in whole degrees, one rotation per cycle. Depends on toc_pkg.
module toc_cordic #(
	parameter int MAG_W = 24,
	parameter int DEN_W = 25,
	parameter int STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              num_neg,
	input  logic [MAG_W-1:0]                  num_mag,
	input  logic [DEN_W-1:0]                  den,
	output logic                              done,
	output logic signed [toc_pkg::ANGLE_W-1:0] angle
);
	import toc_pkg::*;

	localparam int CW     = DEN_W + GUARD_BITS + 3;
	localparam int STEP_N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
	localparam int Q_W    = Z_W - ANGLE_FRAC;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_ROUND
	} cst_t;

	cst_t                    state_q;
	logic signed [CW-1:0]    cx_q;
	logic signed [CW-1:0]    cy_q;
	logic signed [Z_W-1:0]   z_q;
	logic [ATAN_IDX_W-1:0]   cnt_q;
	logic                    done_q;
	logic signed [ANGLE_W-1:0] angle_q;

	logic signed [CW-1:0]    cx0;
	logic signed [CW-1:0]    cy0;
	logic signed [CW-1:0]    dx;
	logic signed [CW-1:0]    dy;
	logic signed [Z_W-1:0]   atan_ext;
	logic [Z_W-1:0]          zmag;
	logic [Z_W-1:0]          zsum;
	logic [Q_W-1:0]          q;
	logic [ANGLE_W-1:0]      qc;
	logic signed [ANGLE_W-1:0] rounded;

	always_comb begin
		cx0 = signed'(CW'(den) << GUARD_BITS);
		cy0 = signed'(CW'(num_mag) << GUARD_BITS);
		if (num_neg) begin
			cy0 = -cy0;
		end
		dx       = cy_q >>> cnt_q;
		dy       = cx_q >>> cnt_q;
		atan_ext = signed'(Z_W'(atan_q16(cnt_q)));
		zmag     = z_q[Z_W-1] ? Z_W'(-z_q) : Z_W'(z_q);
		zsum     = zmag + (Z_W'(1) << (ANGLE_FRAC - 1));
		q        = zsum[Z_W-1:ANGLE_FRAC];
		qc       = (q > Q_W'(MAX_TILT)) ? ANGLE_W'(MAX_TILT) : ANGLE_W'(q);
		rounded  = z_q[Z_W-1] ? signed'(-qc) : signed'(qc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cx_q    <= '0;
			cy_q    <= '0;
			z_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (num_mag == '0) begin
							angle_q <= '0;
							done_q  <= 1'b1;
						end else if (den == '0) begin
							angle_q <= num_neg ? -ANGLE_W'(MAX_TILT) : ANGLE_W'(MAX_TILT);
							done_q  <= 1'b1;
						end else begin
							cx_q    <= cx0;
							cy_q    <= cy0;
							z_q     <= '0;
							cnt_q   <= '0;
							state_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					if (!cy_q[CW-1]) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						z_q  <= z_q + atan_ext;
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						z_q  <= z_q - atan_ext;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ATAN_IDX_W'(STEP_N - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					angle_q <= rounded;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

/* verif/tilt_orientation_classifier_test.sv */
// Self-checking testbench for tilt_orientation_classifier: a bit-exact predictor of the
// scaling, square roots, CORDIC tilts and orientation choice checks every result word.
// Depends on toc_pkg and the block's RTL only.
module tilt_orientation_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import toc_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 200;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int READY_ALWAYS = 0;
	localparam int READY_MOSTLY = 1;
	localparam int READY_RARELY = 2;

	typedef struct packed {
		orient_t            orientation;
		logic               changed;
		logic signed [7:0]  portrait_angle;
		logic signed [7:0]  landscape_angle;
	} tilt_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [3*FIELD_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [23:0]            m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [GAIN_W-1:0]      cfg_wdata = '0;

	logic [GAIN_W-1:0]      gain_shadow = GAIN_RESET;
	logic [THR_W-1:0]       portrait_thr_shadow = THR_RESET;
	logic [THR_W-1:0]       landscape_thr_shadow = THR_RESET;
	orient_t                stored_orientation = ORIENT_UNDEFINED;

	longint atan_deg_q16 [ATAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic [3*FIELD_W-1:0]   sample_backlog [$];
	tilt_result_t           tilt_expected [$];
	tilt_result_t           want_result;

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	bit hold_for_drain = 1'b0;
	bit drained_once = 1'b0;
	int stall_mode = READY_ALWAYS;
	int mode_left = 0;

	tilt_orientation_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic longint scale_sample(input logic signed [FIELD_W-1:0] raw);
		longint          val;
		longint unsigned mag;
		longint unsigned scaled;
		val = raw;
		mag = (val < 0) ? -val : val;
		scaled = (mag * gain_shadow) >> GAIN_FRAC;
		return (val < 0) ? -longint'(scaled) : longint'(scaled);
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic int tilt_degrees(input longint num, input longint unsigned den);
		longint unsigned nmag;
		longint          cx;
		longint          cy;
		longint          acc;
		longint          dx;
		longint          dy;
		longint          mag;
		longint          q;
		int              steps;
		nmag = (num < 0) ? -num : num;
		if (nmag == 0)
			return 0;
		if (den == 0)
			return (num < 0) ? -MAX_TILT : MAX_TILT;
		steps = (CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS_DEF;
		cx = longint'(den << GUARD_BITS);
		cy = longint'(nmag << GUARD_BITS);
		if (num < 0)
			cy = -cy;
		acc = 0;
		for (int i = 0; i < steps; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx = cx + dx;
				cy = cy - dy;
				acc = acc + atan_deg_q16[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				acc = acc - atan_deg_q16[i];
			end
		end
		mag = (acc < 0) ? -acc : acc;
		q = (mag + 32768) >>> ANGLE_FRAC;
		if (q > MAX_TILT)
			q = MAX_TILT;
		return (acc < 0) ? -int'(q) : int'(q);
	endfunction

	function automatic tilt_result_t predict_tilt(input logic [3*FIELD_W-1:0] word);
		longint          x;
		longint          y;
		longint          z;
		longint unsigned xx;
		longint unsigned yy;
		longint unsigned zz;
		int              pa;
		int              la;
		int              pabs;
		int              labs;
		bit              p_hi;
		bit              l_hi;
		orient_t         next;
		tilt_result_t    res;
		x = scale_sample(word[FIELD_W-1:0]);
		y = scale_sample(word[2*FIELD_W-1:FIELD_W]);
		z = scale_sample(word[3*FIELD_W-1:2*FIELD_W]);
		xx = (x < 0) ? -x : x;
		yy = (y < 0) ? -y : y;
		zz = (z < 0) ? -z : z;
		xx = xx * xx;
		yy = yy * yy;
		zz = zz * zz;
		pa = tilt_degrees(x, floor_root(yy + zz));
		la = tilt_degrees(y, floor_root(xx + zz));
		pabs = (pa < 0) ? -pa : pa;
		labs = (la < 0) ? -la : la;
		p_hi = pabs > int'(portrait_thr_shadow);
		l_hi = labs > int'(landscape_thr_shadow);
		next = stored_orientation;
		if (p_hi && !l_hi)
			next = (pa > 0) ? ORIENT_LEFT_UP : ORIENT_RIGHT_UP;
		else if (!p_hi && l_hi)
			next = (la > 0) ? ORIENT_BOTTOM_UP : ORIENT_NORMAL;
		res.orientation = next;
		res.changed = (next != stored_orientation);
		res.portrait_angle = 8'(pa);
		res.landscape_angle = 8'(la);
		stored_orientation = next;
		return res;
	endfunction

	function automatic int signed_between(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic logic [3*FIELD_W-1:0] random_sample();
		logic [2:0][FIELD_W-1:0] f;
		int kind;
		int major;
		int dom;
		kind = $urandom_range(0, 9);
		if (kind < 3) begin
			f[0] = 16'($urandom);
			f[1] = 16'($urandom);
			f[2] = 16'($urandom);
		end else if (kind < 8) begin
			major = $urandom_range(0, 2);
			dom = $urandom_range(200, 32767);
			for (int i = 0; i < 3; i++) begin
				if (i == major)
					f[i] = 16'(($urandom_range(0, 1) != 0) ? dom : -dom);
				else
					f[i] = 16'(signed_between(dom));
			end
		end else begin
			f[0] = 16'(signed_between(3));
			f[1] = 16'(signed_between(3));
			f[2] = 16'(signed_between(3));
		end
		return f;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want_v);
		$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want_v);
		mismatch_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_AXIS_GAIN:     gain_shadow = data;
			REG_PORTRAIT_THR:  portrait_thr_shadow = data[THR_W-1:0];
			REG_LANDSCAPE_THR: landscape_thr_shadow = data[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] pthr,
			input logic [GAIN_W-1:0] lthr);
		write_register(REG_AXIS_GAIN, gain);
		write_register(REG_PORTRAIT_THR, pthr);
		write_register(REG_LANDSCAPE_THR, lthr);
	endtask

	task automatic queue_sample(input int x, input int y, input int z);
		sample_backlog.push_back({16'(z), 16'(y), 16'(x)});
	endtask

	task automatic queue_random(input int count);
		@(negedge clk);
		for (int i = 0; i < count; i++)
			sample_backlog.push_back(random_sample());
	endtask

	task automatic settle();
		while (sample_backlog.size() != 0 || tilt_expected.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				tilt_expected.push_back(predict_tilt(sample_backlog.pop_front()));
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
					if ($urandom_range(0, 15) == 0 || !drained_once)
						hold_for_drain = 1'b1;
				end
			end
			if (s_axis_tvalid && !s_axis_tready) begin
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (hold_for_drain && tilt_expected.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (sample_backlog.size() != 0) begin
				if (hold_for_drain)
					drained_once = 1'b1;
				hold_for_drain = 1'b0;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= sample_backlog[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(READY_ALWAYS, READY_RARELY);
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				READY_ALWAYS: m_axis_tready <= 1'b1;
				READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tilt_expected.size() == 0) begin
				report_mismatch("unexpected result word", int'(m_axis_tdata), 0);
			end else begin
				want_result = tilt_expected.pop_front();
				if (m_axis_tdata[2:0] != want_result.orientation)
					report_mismatch("orientation", int'(m_axis_tdata[2:0]),
						int'(want_result.orientation));
				if (m_axis_tdata[3] != want_result.changed)
					report_mismatch("changed", int'(m_axis_tdata[3]), int'(want_result.changed));
				if (m_axis_tdata[11:4] != want_result.portrait_angle)
					report_mismatch("portrait_angle", int'($signed(m_axis_tdata[11:4])),
						int'(want_result.portrait_angle));
				if (m_axis_tdata[19:12] != want_result.landscape_angle)
					report_mismatch("landscape_angle", int'($signed(m_axis_tdata[19:12])),
						int'(want_result.landscape_angle));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no word accepted for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset register values.
		@(negedge clk);
		queue_sample(0, 0, 0);
		queue_sample(8000, 0, 0);
		queue_sample(8000, 0, 0);
		queue_sample(-8000, 0, 0);
		queue_sample(0, 8000, 0);
		queue_sample(0, -8000, 0);
		queue_sample(0, 0, 8000);
		queue_sample(10000, 10000, 0);
		queue_sample(32767, 32767, 32767);
		queue_sample(-32768, -32768, -32768);
		queue_sample(-32768, 0, 0);
		queue_sample(32767, -32768, 0);
		queue_sample(0, 0, -32768);
		queue_sample(1, 0, 0);
		queue_sample(-1, -1, -1);
		queue_sample(256, 0, 256);
		queue_sample(0, -256, 443);
		queue_sample(300, 300, 10);
		queue_sample(0, 32767, -32768);
		settle();

		set_config(GAIN_RESET, 35, 35);
		queue_random(90);
		settle();

		set_config(32'hFFFF_FFFF, 0, 90);
		queue_sample(32767, -32768, 32767);
		queue_sample(-32768, 32767, -32768);
		queue_random(70);
		settle();

		set_config(32'd0, 35, 35);
		queue_sample(32767, 32767, 32767);
		queue_random(20);
		settle();

		set_config($urandom_range(32'h0040_0000, 32'h0400_0000), 127, 0);
		queue_random(80);
		settle();

		set_config($urandom,
			32'({$urandom_range(0, 32'h01FF_FFFF), 7'($urandom_range(0, 90))}),
			32'({$urandom_range(0, 32'h01FF_FFFF), 7'($urandom_range(0, 90))}));
		queue_random(80);
		settle();

		write_register(REG_UNUSED, $urandom);
		set_config(32'h0100_0000, 90, 127);
		queue_sample(32767, 0, 0);
		queue_sample(0, -32768, 0);
		queue_random(60);
		settle();

		set_config($urandom, $urandom_range(0, 90), $urandom_range(0, 90));
		queue_random(100);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* tilt_orientation_classifier.f */
rtl/core/toc_pkg.sv
rtl/core/toc_isqrt.sv
rtl/core/toc_cordic.sv
rtl/core/tilt_orientation_classifier.sv
verif/tilt_orientation_classifier_test.sv
